FILE: src/swrms_pkg.sv
// Shared types and constants for the sliding window RMS block.
`default_nettype none

package swrms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 17;
  localparam int MS_W       = 31;
  localparam int RMS_W      = 16;
  localparam int ROOT_STEPS = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic                       range_end;
  } in_item_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_value;
    logic [MS_W-1:0]  mean_square;
    logic             is_final;
  } out_item_t;

  typedef enum logic {
    FS_IDLE,
    FS_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_ROOT,
    BS_HOLD
  } back_state_t;

endpackage

`default_nettype wire

FILE: src/sliding_window_rms.sv
// Top level of the sliding window RMS block.
// Moving RMS over the last WINDOW samples, kept as a running sum of squares.
// Input channel: item_valid / item_stall with item (sample, restart,
// range_end). Output channel: result_valid / result_stall with result
// (rms_value, mean_square, is_final). An item moves when valid is high and
// stall is low. restart clears the window before its own sample is taken.
// Every item gives exactly one result, in order.
// Front end: ring read at accept, then sum update and ring write; it takes
// no new item during the update. Back end: a pop, three reciprocal multiply
// steps for the division by WINDOW, 16 root steps and an output hold state.
// The back end pops a new item only after its result is accepted, and so
// sets the rate.
// A two-entry queue sits between the two ends, so samples are still taken
// while a result waits on result_stall; when the queue is full, item_stall
// rises. The result is held steady while stalled.
// Reset empties the window at once through a fill count; no clearing pass.
`default_nettype none

module sliding_window_rms #(
  parameter int WINDOW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire swrms_pkg::in_item_t  item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output swrms_pkg::out_item_t      result
);

  localparam int SUM_W = swrms_pkg::MS_W + $clog2(WINDOW);

  logic             push;
  logic [SUM_W:0]   push_data;
  logic             q_full;
  logic             pop_valid;
  logic             pop_stall;
  logic [SUM_W:0]   pop_data;

  swrms_front #(.WINDOW(WINDOW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  swrms_queue #(.DATA_W(SUM_W + 1)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data)
  );

  swrms_back #(.WINDOW(WINDOW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_stall    (pop_stall),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: src/swrms_front.sv
// Front end: accepts samples, squares them and keeps the ring and running sum.
`default_nettype none

module swrms_front #(
  parameter int WINDOW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire swrms_pkg::in_item_t  item,
  output logic                      push,
  output logic [swrms_pkg::MS_W + $clog2(WINDOW):0] push_data,
  input  wire logic                 q_full
);

  localparam int SUM_W = swrms_pkg::MS_W + $clog2(WINDOW);
  localparam int SLW   = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);

  swrms_pkg::front_state_t state, state_next;

  logic [SLW-1:0]             slot;
  logic [FW-1:0]              fill;
  logic [SUM_W-1:0]           sum;
  logic [swrms_pkg::MS_W-1:0] sq;
  logic                       last;
  logic                       restart_q;
  logic [swrms_pkg::MS_W-1:0] rd_data;
  logic [swrms_pkg::MS_W-1:0] ring [WINDOW];

  logic                       accept;
  logic [SLW-1:0]             rd_addr;
  logic [swrms_pkg::MAG_W-1:0] ext, mag;
  logic [2*swrms_pkg::MAG_W-1:0] prod;
  logic [SLW-1:0]             cur_slot;
  logic [FW-1:0]              cur_fill;
  logic [SUM_W-1:0]           cur_sum;
  logic [swrms_pkg::MS_W-1:0] old;
  logic [SUM_W-1:0]           sum_new;

  assign accept = item_valid && !item_stall;

  // magnitude and exact square of the incoming sample
  always_comb begin
    ext  = {item.sample[swrms_pkg::SAMPLE_W-1], item.sample};
    mag  = ext[swrms_pkg::MAG_W-1] ? (~ext + swrms_pkg::MAG_W'(1)) : ext;
    prod = {{swrms_pkg::MAG_W{1'b0}}, mag} * {{swrms_pkg::MAG_W{1'b0}}, mag};
  end

  assign rd_addr = item.restart ? '0 : slot;

  // restart folds in here: cleared window means slot 0, empty fill, zero sum
  always_comb begin
    cur_slot = restart_q ? '0 : slot;
    cur_fill = restart_q ? '0 : fill;
    cur_sum  = restart_q ? '0 : sum;
    // slots at or past the fill count were not written since the last clear
    old      = (FW'(cur_slot) < cur_fill) ? rd_data : '0;
    sum_new  = cur_sum - SUM_W'(old) + SUM_W'(sq);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      swrms_pkg::FS_IDLE:   if (accept) state_next = swrms_pkg::FS_UPDATE;
      swrms_pkg::FS_UPDATE: state_next = swrms_pkg::FS_IDLE;
      default:              state_next = swrms_pkg::FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall = 1'b1;
    push       = 1'b0;
    case (state)
      swrms_pkg::FS_IDLE:   item_stall = q_full;
      swrms_pkg::FS_UPDATE: push = 1'b1;
      default: begin
        item_stall = 1'b1;
        push       = 1'b0;
      end
    endcase
  end

  assign push_data = {last, sum_new};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrms_pkg::FS_IDLE;
      slot  <= '0;
      fill  <= '0;
      sum   <= '0;
    end else begin
      state <= state_next;
      if (state == swrms_pkg::FS_UPDATE) begin
        sum  <= sum_new;
        slot <= (cur_slot == SLW'(WINDOW - 1)) ? '0 : cur_slot + SLW'(1);
        fill <= (cur_fill == FW'(WINDOW)) ? cur_fill : cur_fill + FW'(1);
      end
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      sq        <= prod[swrms_pkg::MS_W-1:0];
      last      <= item.range_end;
      restart_q <= item.restart;
    end
  end

  // square ring memory, registered read at accept
  always_ff @(posedge clk) begin
    if (accept) rd_data <= ring[rd_addr];
    if (state == swrms_pkg::FS_UPDATE) ring[cur_slot] <= sq;
  end

endmodule

`default_nettype wire

FILE: src/swrms_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module swrms_queue #(
  parameter int DATA_W = 36
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  output logic                   pop_valid,
  input  wire logic              pop_stall,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && !pop_stall;
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) entry[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

FILE: src/swrms_back.sv
// Back end: divides the running sum by the window and takes its square root.
`default_nettype none

module swrms_back #(
  parameter int WINDOW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pop_valid,
  output logic                       pop_stall,
  input  wire logic [swrms_pkg::MS_W + $clog2(WINDOW):0] pop_data,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output swrms_pkg::out_item_t       result
);

  localparam int SUM_W   = swrms_pkg::MS_W + $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int CHUNK_W = 16;
  localparam int NCHUNK  = (SUM_W + CHUNK_W) / CHUNK_W;
  localparam int RCP_W   = NCHUNK * CHUNK_W;
  localparam int ACC_W   = SUM_W + RCP_W;
  localparam int CW      = $clog2(swrms_pkg::ROOT_STEPS);
  localparam int MS_W    = swrms_pkg::MS_W;
  // ceil(2^SHIFT / WINDOW): gives the exact floor quotient for any SUM_W-bit sum
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

  swrms_pkg::back_state_t state, state_next;

  logic [CW-1:0]    cnt;
  logic [SUM_W-1:0] dvd;
  logic [RCP_W-1:0] rcp;
  logic [ACC_W-1:0] acc;
  logic             last;
  logic [MS_W-1:0]  mean;
  logic [MS_W-1:0]  v;
  logic [MS_W:0]    res;
  logic [MS_W-1:0]  rbit;

  logic [SUM_W+CHUNK_W-1:0] part;
  logic [ACC_W-1:0] acc_next;
  logic [MS_W:0]    rsum;
  logic             rtake;
  logic [MS_W:0]    res_next;

  // reciprocal multiply, one CHUNK_W-bit slice per cycle, top slice first
  always_comb begin
    part     = {{CHUNK_W{1'b0}}, dvd} * {{SUM_W{1'b0}}, rcp[RCP_W-1 -: CHUNK_W]};
    acc_next = {acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(part);
  end

  // one root digit per cycle
  always_comb begin
    rsum     = res + {1'b0, rbit};
    rtake    = ({1'b0, v} >= rsum);
    res_next = rtake ? ((res >> 1) + {1'b0, rbit}) : (res >> 1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      swrms_pkg::BS_IDLE: if (pop_valid) state_next = swrms_pkg::BS_DIV;
      swrms_pkg::BS_DIV:  if (cnt == '0) state_next = swrms_pkg::BS_ROOT;
      swrms_pkg::BS_ROOT: if (cnt == '0) state_next = swrms_pkg::BS_HOLD;
      swrms_pkg::BS_HOLD: if (!result_stall) state_next = swrms_pkg::BS_IDLE;
      default:            state_next = swrms_pkg::BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_stall    = 1'b1;
    result_valid = 1'b0;
    case (state)
      swrms_pkg::BS_IDLE: pop_stall = 1'b0;
      swrms_pkg::BS_HOLD: result_valid = 1'b1;
      default: begin
        pop_stall    = 1'b1;
        result_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= swrms_pkg::BS_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      swrms_pkg::BS_IDLE: begin
        dvd  <= pop_data[SUM_W-1:0];
        last <= pop_data[SUM_W];
        acc  <= '0;
        rcp  <= RECIP;
        cnt  <= CW'(NCHUNK - 1);
      end
      swrms_pkg::BS_DIV: begin
        acc  <= acc_next;
        rcp  <= rcp << CHUNK_W;
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          mean <= acc_next[SHIFT +: MS_W];
          v    <= acc_next[SHIFT +: MS_W];
          res  <= '0;
          rbit <= MS_W'(1) << (MS_W - 1);
          cnt  <= CW'(swrms_pkg::ROOT_STEPS - 1);
        end
      end
      swrms_pkg::BS_ROOT: begin
        if (rtake) v <= v - rsum[MS_W-1:0];
        res  <= res_next;
        rbit <= rbit >> 2;
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          result.rms_value   <= res_next[swrms_pkg::RMS_W-1:0];
          result.mean_square <= mean;
          result.is_final    <= last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/swrms_checker.sv
// Port-level assertions for the sliding window RMS block, with its bind.
`default_nettype none

module swrms_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire swrms_pkg::out_item_t result
);

  logic [33:0] r2;
  logic [33:0] r2n;
  logic [33:0] ms;

  assign r2  = {18'b0, result.rms_value} * {18'b0, result.rms_value};
  assign r2n = ({18'b0, result.rms_value} + 34'd1) * ({18'b0, result.rms_value} + 34'd1);
  assign ms  = {3'b0, result.mean_square};

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // root is the floor square root of the mean square
  a_root: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (r2 <= ms) && (ms < r2n))
    else $error("rms_value is not the floor root of mean_square");

  // mean square never exceeds the square of the most negative sample
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.mean_square <= 31'h4000_0000)
    else $error("mean_square out of range");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind sliding_window_rms swrms_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for sliding_window_rms against a window model.
`timescale 1ns / 100ps

module testbench;

  localparam int WIN         = 16;
  localparam int SUM_W       = 35;
  localparam int RESET_CYC   = 10;
  localparam int DRAIN_CYC   = 120;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYC    = 400;
  localparam int PAUSE_AT    = 500;
  localparam int PHASE_LEN   = 60;
  localparam int RAND_ITEMS  = 700;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    ST_ANY,
    ST_EDGE,
    ST_SMALL,
    ST_LOUD
  } sample_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  swrms_pkg::in_item_t  item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  swrms_pkg::out_item_t result;

  swrms_pkg::in_item_t  pending_q[$];
  swrms_pkg::out_item_t rms_expect_q[$];

  // window model state
  logic [swrms_pkg::MS_W-1:0] sq_ring[WIN];
  logic [SUM_W-1:0]           sq_total;
  int unsigned                oldest_slot;

  int n_accepted = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  sliding_window_rms #(.WINDOW(WIN)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // idling pattern changes every PHASE_LEN accepted items
  function automatic idle_mode_t mode_of(int n);
    return idle_mode_t'((n / PHASE_LEN) % 4);
  endfunction

  // floor of the integer square root, built bit by bit from the top
  function automatic logic [swrms_pkg::RMS_W-1:0] floor_root(
    logic [swrms_pkg::MS_W-1:0] v);
    logic [swrms_pkg::RMS_W:0] root;
    logic [swrms_pkg::RMS_W:0] trial;
    root = '0;
    for (int b = swrms_pkg::RMS_W; b >= 0; b--) begin
      trial = root | ((swrms_pkg::RMS_W+1)'(1) << b);
      if (34'(trial) * 34'(trial) <= 34'(v)) root = trial;
    end
    return root[swrms_pkg::RMS_W-1:0];
  endfunction

  // update the window with one sample and return the expected result
  function automatic swrms_pkg::out_item_t window_rms(swrms_pkg::in_item_t it);
    logic [swrms_pkg::MAG_W-1:0] mag;
    logic [swrms_pkg::MS_W-1:0]  sq;
    logic [SUM_W-1:0]            mean_wide;
    swrms_pkg::out_item_t        r;
    if (it.restart) begin
      foreach (sq_ring[i]) sq_ring[i] = '0;
      sq_total = '0;
      oldest_slot = 0;
    end
    mag = it.sample[swrms_pkg::SAMPLE_W-1]
          ? (swrms_pkg::MAG_W'(17'h10000) - {1'b0, it.sample})
          : {1'b0, it.sample};
    sq = mag * mag;
    sq_total = sq_total - SUM_W'(sq_ring[oldest_slot]) + SUM_W'(sq);
    sq_ring[oldest_slot] = sq;
    oldest_slot = (oldest_slot + 1) % WIN;
    mean_wide = sq_total / WIN;
    r.mean_square = mean_wide[swrms_pkg::MS_W-1:0];
    r.rms_value   = floor_root(r.mean_square);
    r.is_final    = it.range_end;
    return r;
  endfunction

  task automatic add_sample(int s, bit rs, bit last);
    swrms_pkg::in_item_t it;
    it.sample    = s[swrms_pkg::SAMPLE_W-1:0];
    it.restart   = rs;
    it.range_end = last;
    pending_q = {pending_q, it};
  endtask

  function automatic int pick_sample();
    int edge_vals[5] = '{-32768, 32767, 0, -1, 1};
    sample_style_t st;
    st = sample_style_t'($urandom_range(0, 3));
    case (st)
      ST_EDGE:  return edge_vals[$urandom_range(0, 4)];
      ST_SMALL: return int'($urandom_range(0, 200)) - 100;
      ST_LOUD:  return $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 255))
                                            : 32767 - int'($urandom_range(0, 255));
      default:  return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // driver: presents items from pending_q, holds a stalled item steady
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        rms_expect_q = {rms_expect_q, window_rms(item)};
        n_accepted <= n_accepted + 1;
      end
      if (!item_valid || !item_stall) begin
        if (!pause_done && n_accepted >= PAUSE_AT && rms_expect_q.size() != 0) begin
          // hold off until the block has delivered everything
          item_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          item_valid <= 1'b0;
        end else if (hold_left == 0 &&
                     ((mode_of(n_accepted) == IDLE_SEND && $urandom_range(0, 99) < 62) ||
                      (mode_of(n_accepted) == IDLE_BOTH && $urandom_range(0, 99) < 21))) begin
          item_valid <= 1'b0;
        end else begin
          if (n_accepted >= PAUSE_AT) pause_done = 1'b1;
          item_valid <= 1'b1;
          item       <= pending_q.pop_front();
        end
      end
    end
  end

  // one long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYC;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted result and drives result_stall
  always @(posedge clk) begin
    swrms_pkg::out_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (rms_expect_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: rms %0d ms %0d final %0d",
                     result.rms_value, result.mean_square, result.is_final);
          mismatches++;
        end else begin
          want = rms_expect_q.pop_front();
          if (result !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("mismatch: rms %0d/%0d ms %0d/%0d final %0d/%0d (exp/act)",
                       want.rms_value, result.rms_value, want.mean_square,
                       result.mean_square, want.is_final, result.is_final);
            mismatches++;
          end
        end
      end
      // the long hold-off lets the block back up into its input
      if (hold_left != 0 || (!hold_done && n_accepted >= HOLD_AT)) begin
        result_stall <= 1'b1;
      end else begin
        case (mode_of(n_accepted))
          IDLE_RECV: result_stall <= ($urandom_range(0, 99) < 62);
          IDLE_BOTH: result_stall <= ($urandom_range(0, 99) < 21);
          default:   result_stall <= 1'b0;
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    int total;
    int len;
    foreach (sq_ring[i]) sq_ring[i] = '0;
    sq_total = '0;
    oldest_slot = 0;

    // directed: partial window after reset, sign extremes
    add_sample(32767, 1'b0, 1'b0);
    add_sample(0, 1'b0, 1'b0);
    add_sample(-1, 1'b0, 1'b0);
    add_sample(1, 1'b0, 1'b0);
    add_sample(-32768, 1'b0, 1'b1);
    // full window of most negative samples, mean square 2^30
    add_sample(-32768, 1'b1, 1'b0);
    for (int i = 0; i < WIN - 2; i++) add_sample(-32768, 1'b0, 1'b0);
    add_sample(-32768, 1'b0, 1'b1);
    // wrap past the window, then restart on the range end
    add_sample(-32768, 1'b0, 1'b0);
    add_sample(32767, 1'b0, 1'b0);
    add_sample(0, 1'b1, 1'b1);

    // random: mostly ranges opened by restart, some noise
    total = 0;
    while (total < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
          add_sample(pick_sample(), i == 0, i == len - 1);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          add_sample(pick_sample(), $urandom_range(0, 1), $urandom_range(0, 1));
      end
      total += len;
    end

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || item_valid || rms_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0)
      $display("PASS sliding_window_rms");
    else
      $display("FAIL sliding_window_rms");
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL sliding_window_rms");
    $finish;
  end

endmodule
